@@ design/sps_pkg.sv @@
// Shared types and constants for the stepper position sequencer.
package sps_pkg;

   localparam int POS_W      = 16;
   localparam int MAX_W      = 15;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 16;

   typedef logic signed [POS_W-1:0] pos_type;
   typedef logic [MAX_W-1:0]        maxpos_type;

   // Item kinds on the request channel
   typedef enum logic {
      CMD_TICK = 1'b0,
      CMD_GOAL = 1'b1
   } cmd_type;

   // Configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_MAX_POSITION = 8'd0,
      REG_START_GOAL   = 8'd1
   } reg_index_type;

   localparam maxpos_type  MAX_POSITION_RESET = 15'd1000;
   localparam pos_type     START_GOAL_RESET   = 16'sd0;
   // Ticks per step: forward moves run slow, backward moves every tick
   localparam logic [2:0]  FWD_DIVIDER        = 3'd7;
   localparam logic [2:0]  REV_DIVIDER        = 3'd0;

   // One result beat
   typedef struct packed {
      logic    coil_a;
      logic    coil_b;
      logic    coil_c;
      logic    coil_d;
      pos_type position;
      logic    homed;
      logic    goal_accepted;
   } rsp_payload_type;

   // Current motor state as seen by the top level
   typedef struct packed {
      pos_type position;
      logic    homed;
   } core_status_type;

endpackage

@@ design/sps_req_if.sv @@
// Request channel: tick or goal command beats.
interface sps_req_if;
   import sps_pkg::*;

   logic    valid;
   logic    ready;
   logic    cmd;
   pos_type goal;

   modport source (output valid, output cmd, output goal, input ready);
   modport sink   (input valid, input cmd, input goal, output ready);
endinterface

@@ design/sps_rsp_if.sv @@
// Result channel: coil drive pattern and position status beats.
interface sps_rsp_if;
   import sps_pkg::*;

   logic    valid;
   logic    ready;
   logic    coil_a;
   logic    coil_b;
   logic    coil_c;
   logic    coil_d;
   pos_type position;
   logic    homed;
   logic    goal_accepted;

   modport source (output valid, output coil_a, output coil_b, output coil_c, output coil_d,
                   output position, output homed, output goal_accepted, input ready);
   modport sink   (input valid, input coil_a, input coil_b, input coil_c, input coil_d,
                   input position, input homed, input goal_accepted, output ready);
endinterface

@@ design/sps_csr_if.sv @@
// Configuration write channel.
interface sps_csr_if;
   import sps_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

@@ design/sps_csr.sv @@
// Configuration register file of the stepper position sequencer.
module sps_csr (
   input  logic               clock,
   input  logic               reset,
   sps_csr_if.sink            csr_bus,
   output sps_pkg::maxpos_type max_position
);
   import sps_pkg::*;

   maxpos_type max_position_ff;
   maxpos_type max_position_in;

   // Writes are always taken
   assign csr_bus.ready = 1'b1;

   // Register decode; start goal is reloaded by reset together with target,
   // so a write to it leaves no lasting effect and needs no storage
   always_comb begin
      max_position_in = max_position_ff;
      if (csr_bus.valid) begin
         unique case (csr_bus.index)
            REG_MAX_POSITION: max_position_in = csr_bus.data[MAX_W-1:0];
            REG_START_GOAL:   max_position_in = max_position_ff;
            default:          max_position_in = max_position_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_position_ff <= MAX_POSITION_RESET;
      end else begin
         max_position_ff <= max_position_in;
      end
   end

   assign max_position = max_position_ff;

endmodule

@@ design/sps_core.sv @@
// Motor state registers and the combinational step/goal update logic.
module sps_core (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step_en,
   input  logic                    cmd,
   input  sps_pkg::pos_type        goal,
   input  sps_pkg::maxpos_type     max_position,
   output sps_pkg::rsp_payload_type result,
   output sps_pkg::core_status_type status
);
   import sps_pkg::*;

   pos_type    pos_ff, pos_in;
   pos_type    target_ff, target_in;
   logic [1:0] phase_ff, phase_in;
   logic       homed_ff, homed_in;
   logic [2:0] tick_ff, tick_in;
   logic [2:0] div_ff, div_in;
   logic       accepted;
   logic [3:0] tick_next;
   pos_type    max_ext;

   assign max_ext   = pos_type'({1'b0, max_position});
   assign tick_next = {1'b0, tick_ff} + 4'd1;

   // Next state for one beat
   always_comb begin
      pos_in    = pos_ff;
      target_in = target_ff;
      phase_in  = phase_ff;
      homed_in  = homed_ff;
      tick_in   = tick_ff;
      div_in    = div_ff;
      accepted  = 1'b0;
      if (cmd == CMD_TICK) begin
         if (!homed_ff) begin
            // homing run: step forward until the end position
            if (pos_ff != max_ext) begin
               pos_in   = pos_ff + 16'sd1;
               phase_in = phase_ff + 2'd1;
            end else begin
               homed_in = 1'b1;
               tick_in  = 3'd0;
               div_in   = 3'd0;
            end
         end else if (tick_next >= {1'b0, div_ff}) begin
            tick_in = 3'd0;
            if (target_ff > pos_ff) begin
               pos_in   = pos_ff + 16'sd1;
               phase_in = phase_ff + 2'd1;
            end else if (target_ff < pos_ff) begin
               pos_in   = pos_ff - 16'sd1;
               phase_in = phase_ff - 2'd1;
            end
         end else begin
            tick_in = tick_next[2:0];
         end
      end else if (goal <= max_ext) begin
         // goal at or below the maximum position: pick divider by direction
         div_in    = (goal < pos_ff) ? REV_DIVIDER : FWD_DIVIDER;
         target_in = goal;
         accepted  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         target_ff <= START_GOAL_RESET;
         phase_ff  <= '0;
         homed_ff  <= 1'b0;
         tick_ff   <= '0;
         div_ff    <= '0;
      end else if (step_en) begin
         pos_ff    <= pos_in;
         target_ff <= target_in;
         phase_ff  <= phase_in;
         homed_ff  <= homed_in;
         tick_ff   <= tick_in;
         div_ff    <= div_in;
      end
   end

   // Two-phase-on coil pattern from the updated phase
   always_comb begin
      result.coil_a        = (phase_in == 2'd0) || (phase_in == 2'd3);
      result.coil_b        = (phase_in == 2'd0) || (phase_in == 2'd1);
      result.coil_c        = (phase_in == 2'd1) || (phase_in == 2'd2);
      result.coil_d        = (phase_in == 2'd2) || (phase_in == 2'd3);
      result.position      = pos_in;
      result.homed         = homed_in;
      result.goal_accepted = accepted;
   end

   assign status.position = pos_ff;
   assign status.homed    = homed_ff;

endmodule

@@ design/stepper_position_sequencer.sv @@
// Top level of the stepper position sequencer.
// Full-step, two-phase-on position control for a four-coil stepper. Each request
// beat is a tick or a goal command and produces exactly one result beat carrying
// the coil pattern, position, homed flag and goal acceptance. A beat is accepted
// every clock cycle while the result register is empty or being drained; the
// result is registered and appears in the cycle after acceptance. The whole
// update is one pass of logic between the state registers and the result
// register. Configuration writes are accepted every cycle.
module stepper_position_sequencer (
   input logic     clock,
   input logic     reset,
   sps_req_if.sink   req_bus,
   sps_rsp_if.source rsp_bus,
   sps_csr_if.sink   csr_bus
);
   import sps_pkg::*;

   maxpos_type      max_position;
   rsp_payload_type result;
   core_status_type status;
   logic            req_accept;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff, rsp_data_in;

   sps_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_bus      (csr_bus),
      .max_position (max_position)
   );

   sps_core u_core (
      .clock        (clock),
      .reset        (reset),
      .step_en      (req_accept),
      .cmd          (req_bus.cmd),
      .goal         (req_bus.goal),
      .max_position (max_position),
      .result       (result),
      .status       (status)
   );

   // Handshake: take a beat whenever the result slot is free or draining
   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign req_accept    = req_bus.valid && req_bus.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.coil_a        = rsp_data_ff.coil_a;
   assign rsp_bus.coil_b        = rsp_data_ff.coil_b;
   assign rsp_bus.coil_c        = rsp_data_ff.coil_c;
   assign rsp_bus.coil_d        = rsp_data_ff.coil_d;
   assign rsp_bus.position      = rsp_data_ff.position;
   assign rsp_bus.homed         = rsp_data_ff.homed;
   assign rsp_bus.goal_accepted = rsp_data_ff.goal_accepted;

   // A tick never reports an accepted goal, and always yields a result beat
   a_tick_result : assert property (@(posedge clock) disable iff (reset)
      req_accept && (req_bus.cmd == CMD_TICK) |=> rsp_bus.valid && !rsp_bus.goal_accepted)
      else $error("tick beat produced bad result");

   // A goal command never moves the motor
   a_goal_no_move : assert property (@(posedge clock) disable iff (reset)
      req_accept && (req_bus.cmd == CMD_GOAL) |=> rsp_bus.position == $past(status.position))
      else $error("goal command moved the motor");

   // Homed flag only clears on reset
   a_homed_sticky : assert property (@(posedge clock) disable iff (reset)
      status.homed |=> status.homed)
      else $error("homed flag dropped");

endmodule
